// File: design/bbf_pkg.sv
// Package for the Butterworth biquad filter: register indexes of the
// configuration channel and bit positions inside the tuser sidebands.
// No dependencies.
package bbf_pkg;

   // Configuration channel index width and register indexes
   localparam int CSR_INDEX_BITS = 3;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FF_GAIN     = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FF_MID      = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FF_LAST     = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FB_MID      = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FB_LAST     = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BYPASS_MODE = 3'd5;

   // Bypass codes
   localparam logic [1:0] BYPASS_NONE    = 2'd0;
   localparam logic [1:0] BYPASS_THROUGH = 2'd1;

   // Sideband layout
   localparam int REQ_USER_BITS  = 2;
   localparam int REQ_USER_SILENT = 0;
   localparam int REQ_USER_CLEAR  = 1;
   localparam int RSP_USER_BITS  = 1;
   localparam int RSP_USER_CLIP  = 0;

endpackage

// File: design/butterworth_biquad_filter.sv
// Second-order biquad (direct form II) with one shared multiplier under a
// small sequencer. Coefficients and bypass come from the csr_ write channel.
// Depends on bbf_pkg.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+----------------------------------------
//  req_    | in  | req_tvalid/req_tready | tdata: in_sample; tuser: silent, clear
//  rsp_    | out | rsp_tvalid/rsp_tready | tdata: out_sample; tuser: clipped
//  csr_    | in  | csr_valid/csr_ready   | csr_index, csr_data (always ready)
//
// A filtered sample is in the output register after five products of two
// half-width multiplies each (low, high and add steps a product), then
// rounding and saturation. A new request is taken only once the sequencer is
// back in idle. Silent and bypass items skip the multiplies. Reset is
// synchronous, restores unity gain and zeroes the history. A stalled rsp_ side
// holds the next result in the sequencer until the output register frees.
module butterworth_biquad_filter #(
   parameter int SAMPLE_BITS    = 24,
   parameter int COEF_FRAC_BITS = 22,
   parameter int HISTORY_BITS   = 40
) (
   input  logic                                      clock,
   input  logic                                      reset,
   // request stream
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]          req_tdata,  // in_sample
   input  logic [bbf_pkg::REQ_USER_BITS-1:0]         req_tuser,  // silent, clear_history
   // response stream
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   output logic [((SAMPLE_BITS+7)/8)*8-1:0]          rsp_tdata,  // out_sample
   output logic [bbf_pkg::RSP_USER_BITS-1:0]         rsp_tuser,  // clipped
   // configuration writes
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [bbf_pkg::CSR_INDEX_BITS-1:0]        csr_index,
   input  logic [COEF_FRAC_BITS+2:0]                 csr_data
);

   localparam int CB  = COEF_FRAC_BITS + 3;           // coefficient width
   localparam int HB  = HISTORY_BITS;
   localparam int SB  = SAMPLE_BITS;
   localparam int DW  = ((SAMPLE_BITS + 7) / 8) * 8;  // tdata width
   localparam int LOW = (HISTORY_BITS + 1) / 2;       // low split of history operand
   localparam int AW  = LOW + 1;                      // multiplier operand width
   localparam int MW  = AW + CB;                      // multiplier result width
   localparam int PW  = HB + CB;                      // full product width
   localparam int RW  = PW + 1 - COEF_FRAC_BITS;      // rounded product width
   localparam int SW  = HB + 6;                       // accumulator width

   localparam logic signed [CB-1:0] GAIN_ONE = CB'(1) <<< COEF_FRAC_BITS;
   localparam logic signed [PW:0]   RND_HALF = (PW+1)'(1) <<< (COEF_FRAC_BITS - 1);
   localparam logic signed [SW-1:0] H_MAX    = (SW'(1) <<< (HB - 1)) - SW'(1);
   localparam logic signed [SW-1:0] H_MIN    = -H_MAX - SW'(1);
   localparam logic signed [SW-1:0] S_MAX    = (SW'(1) <<< (SB - 1)) - SW'(1);
   localparam logic signed [SW-1:0] S_MIN    = -S_MAX - SW'(1);

   // sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CALC  = 3'd1;
   localparam logic [2:0] ST_FIN   = 3'd2;
   localparam logic [2:0] ST_YSAT  = 3'd3;
   localparam logic [2:0] ST_WRITE = 3'd4;

   // product order: fb_mid*h1, fb_last*h2, ff_mid*h1, ff_last*h2, ff_gain*t
   localparam logic [2:0] P_FB_MID  = 3'd0;
   localparam logic [2:0] P_FB_LAST = 3'd1;
   localparam logic [2:0] P_FF_MID  = 3'd2;
   localparam logic [2:0] P_FF_LAST = 3'd3;
   localparam logic [2:0] P_FF_GAIN = 3'd4;

   // sub-steps of one product
   localparam logic [1:0] SUB_LO  = 2'd0;
   localparam logic [1:0] SUB_HI  = 2'd1;
   localparam logic [1:0] SUB_ADD = 2'd2;

   // configuration registers
   logic signed [CB-1:0] ff_gain_ff, ff_gain_in;
   logic signed [CB-1:0] ff_mid_ff, ff_mid_in;
   logic signed [CB-1:0] ff_last_ff, ff_last_in;
   logic signed [CB-1:0] fb_mid_ff, fb_mid_in;
   logic signed [CB-1:0] fb_last_ff, fb_last_in;
   logic [1:0]           bypass_ff, bypass_in;

   // control
   logic [2:0] state_ff, state_in;
   logic [2:0] pidx_ff, pidx_in;
   logic [1:0] sub_ff, sub_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // history and datapath
   logic signed [HB-1:0] h1_ff, h1_in;
   logic signed [HB-1:0] h2_ff, h2_in;
   logic signed [HB-1:0] t_ff, t_in;
   logic signed [MW-1:0] mul_ff, mul_in;
   logic signed [PW-1:0] pacc_ff, pacc_in;
   logic signed [SW-1:0] sum_a_ff, sum_a_in;
   logic signed [SW-1:0] sum_b_ff, sum_b_in;
   logic                 clip_ff, clip_in;
   logic signed [SB-1:0] res_ff, res_in;
   logic                 res_clip_ff, res_clip_in;
   logic signed [SB-1:0] out_ff, out_in;
   logic                 out_clip_ff, out_clip_in;

   // combinational helpers
   logic                 req_fire;
   logic                 out_free;
   logic signed [SB-1:0] x_in;
   logic signed [HB-1:0] mul_op;
   logic signed [CB-1:0] mul_coef;
   logic signed [AW-1:0] mul_a;
   logic signed [MW-1:0] mul_prod;
   logic signed [PW:0]   pacc_ext;
   logic signed [PW:0]   rnd_neg;
   logic signed [PW:0]   rnd_sum;
   logic signed [RW-1:0] rnd_q;
   logic signed [SW-1:0] rnd_ext;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign x_in       = signed'(req_tdata[SB-1:0]);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DW'(unsigned'(out_ff));
   assign rsp_tuser  = bbf_pkg::RSP_USER_BITS'(out_clip_ff);

   // operand and coefficient for the current product
   always_comb begin
      mul_op   = t_ff;
      mul_coef = ff_gain_ff;
      unique case (pidx_ff)
         P_FB_MID:  begin mul_op = h1_ff; mul_coef = fb_mid_ff;  end
         P_FB_LAST: begin mul_op = h2_ff; mul_coef = fb_last_ff; end
         P_FF_MID:  begin mul_op = h1_ff; mul_coef = ff_mid_ff;  end
         P_FF_LAST: begin mul_op = h2_ff; mul_coef = ff_last_ff; end
         default:   begin mul_op = t_ff;  mul_coef = ff_gain_ff; end
      endcase
   end

   // shared multiplier: low half unsigned, high half signed
   always_comb begin
      if (sub_ff == SUB_LO) begin
         mul_a = signed'({1'b0, mul_op[LOW-1:0]});
      end else begin
         mul_a = AW'(signed'(mul_op[HB-1:LOW]));
      end
      mul_prod = mul_a * mul_coef;
   end

   // round to nearest, ties away from zero, then drop the fraction bits
   always_comb begin
      pacc_ext = signed'({pacc_ff[PW-1], pacc_ff});
      rnd_neg  = signed'({{PW{1'b0}}, pacc_ff[PW-1]});
      rnd_sum  = pacc_ext + RND_HALF - rnd_neg;
      rnd_q    = signed'(rnd_sum[PW:COEF_FRAC_BITS]);
      rnd_ext  = SW'(rnd_q);
   end

   // configuration writes
   always_comb begin
      ff_gain_in = ff_gain_ff;
      ff_mid_in  = ff_mid_ff;
      ff_last_in = ff_last_ff;
      fb_mid_in  = fb_mid_ff;
      fb_last_in = fb_last_ff;
      bypass_in  = bypass_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            bbf_pkg::CSR_FF_GAIN:     ff_gain_in = signed'(csr_data);
            bbf_pkg::CSR_FF_MID:      ff_mid_in  = signed'(csr_data);
            bbf_pkg::CSR_FF_LAST:     ff_last_in = signed'(csr_data);
            bbf_pkg::CSR_FB_MID:      fb_mid_in  = signed'(csr_data);
            bbf_pkg::CSR_FB_LAST:     fb_last_in = signed'(csr_data);
            bbf_pkg::CSR_BYPASS_MODE: bypass_in  = csr_data[1:0];
            default:                  ;
         endcase
      end
   end

   // sequencer and datapath
   always_comb begin
      state_in     = state_ff;
      pidx_in      = pidx_ff;
      sub_in       = sub_ff;
      rsp_valid_in = rsp_valid_ff;
      h1_in        = h1_ff;
      h2_in        = h2_ff;
      t_in         = t_ff;
      mul_in       = mul_ff;
      pacc_in      = pacc_ff;
      sum_a_in     = sum_a_ff;
      sum_b_in     = sum_b_ff;
      clip_in      = clip_ff;
      res_in       = res_ff;
      res_clip_in  = res_clip_ff;
      out_in       = out_ff;
      out_clip_in  = out_clip_ff;

      // output register drains independently
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser[bbf_pkg::REQ_USER_CLEAR]) begin
                  h1_in = '0;
                  h2_in = '0;
               end
               res_clip_in = 1'b0;
               if (req_tuser[bbf_pkg::REQ_USER_SILENT] || bypass_ff[1]) begin
                  res_in   = '0;
                  state_in = ST_WRITE;
               end else if (bypass_ff == bbf_pkg::BYPASS_THROUGH) begin
                  res_in   = x_in;
                  state_in = ST_WRITE;
               end else begin
                  sum_a_in = SW'(x_in);
                  sum_b_in = '0;
                  clip_in  = 1'b0;
                  pidx_in  = P_FB_MID;
                  sub_in   = SUB_LO;
                  state_in = ST_CALC;
               end
            end
         end

         ST_CALC: begin
            case (sub_ff)
               SUB_LO: begin
                  mul_in = mul_prod;
                  // fold in the previous product
                  if (pidx_ff == P_FB_LAST || pidx_ff == P_FF_MID) begin
                     sum_a_in = sum_a_ff - rnd_ext;
                  end else if (pidx_ff == P_FF_LAST || pidx_ff == P_FF_GAIN) begin
                     sum_b_in = sum_b_ff + rnd_ext;
                  end
                  sub_in = SUB_HI;
               end
               SUB_HI: begin
                  mul_in  = mul_prod;
                  pacc_in = PW'(mul_ff);
                  // feedback sum is complete: saturate to the history width
                  if (pidx_ff == P_FF_MID) begin
                     if (sum_a_ff > H_MAX) begin
                        t_in    = HB'(H_MAX);
                        clip_in = 1'b1;
                     end else if (sum_a_ff < H_MIN) begin
                        t_in    = HB'(H_MIN);
                        clip_in = 1'b1;
                     end else begin
                        t_in = HB'(sum_a_ff);
                     end
                  end
                  sub_in = SUB_ADD;
               end
               default: begin
                  pacc_in = pacc_ff + (PW'(mul_ff) <<< LOW);
                  sub_in  = SUB_LO;
                  if (pidx_ff == P_FF_GAIN) begin
                     state_in = ST_FIN;
                  end else begin
                     pidx_in = pidx_ff + 3'd1;
                  end
               end
            endcase
         end

         ST_FIN: begin
            sum_b_in = sum_b_ff + rnd_ext;
            state_in = ST_YSAT;
         end

         ST_YSAT: begin
            // output saturation and history shift
            if (sum_b_ff > S_MAX) begin
               res_in      = SB'(S_MAX);
               res_clip_in = 1'b1;
            end else if (sum_b_ff < S_MIN) begin
               res_in      = SB'(S_MIN);
               res_clip_in = 1'b1;
            end else begin
               res_in      = SB'(sum_b_ff);
               res_clip_in = clip_ff;
            end
            h2_in    = h1_ff;
            h1_in    = t_ff;
            state_in = ST_WRITE;
         end

         ST_WRITE: begin
            if (out_free) begin
               out_in       = res_ff;
               out_clip_in  = res_clip_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pidx_ff      <= P_FB_MID;
         sub_ff       <= SUB_LO;
         rsp_valid_ff <= 1'b0;
         h1_ff        <= '0;
         h2_ff        <= '0;
         ff_gain_ff   <= GAIN_ONE;
         ff_mid_ff    <= '0;
         ff_last_ff   <= '0;
         fb_mid_ff    <= '0;
         fb_last_ff   <= '0;
         bypass_ff    <= bbf_pkg::BYPASS_NONE;
      end else begin
         state_ff     <= state_in;
         pidx_ff      <= pidx_in;
         sub_ff       <= sub_in;
         rsp_valid_ff <= rsp_valid_in;
         h1_ff        <= h1_in;
         h2_ff        <= h2_in;
         ff_gain_ff   <= ff_gain_in;
         ff_mid_ff    <= ff_mid_in;
         ff_last_ff   <= ff_last_in;
         fb_mid_ff    <= fb_mid_in;
         fb_last_ff   <= fb_last_in;
         bypass_ff    <= bypass_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      t_ff        <= t_in;
      mul_ff      <= mul_in;
      pacc_ff     <= pacc_in;
      sum_a_ff    <= sum_a_in;
      sum_b_ff    <= sum_b_in;
      clip_ff     <= clip_in;
      res_ff      <= res_in;
      res_clip_ff <= res_clip_in;
      out_ff      <= out_in;
      out_clip_ff <= out_clip_in;
   end

endmodule
